>>> hw/rtl/teq_pkg.sv
package teq_pkg;

  localparam int CAPACITY = 256;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int TIME_W   = 32;
  localparam int ID_W     = 4;
  localparam int SEQ_W    = 16;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [TIME_W-1:0] evt_time_t;

  localparam idx_t LAST_IDX = idx_t'(CAPACITY - 1);

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_POP    = 1'b1;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_POPPED   = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  // packed as sequence, origin, receiver, sender (msb to lsb)
  typedef struct packed {
    logic [SEQ_W-1:0] sequence_number;
    logic [ID_W-1:0]  origin_id;
    logic [ID_W-1:0]  receiver_id;
    logic [ID_W-1:0]  sender_id;
  } hdr_t;

  typedef struct packed {
    logic      rd_en;
    idx_t      rd_addr;
    logic      wr_en;
    idx_t      wr_addr;
    evt_time_t wr_time;
    hdr_t      wr_hdr;
    logic      clr_en;
    idx_t      clr_addr;
  } store_req_t;

  typedef struct packed {
    logic      rd_valid;
    evt_time_t rd_time;
    hdr_t      rd_hdr;
  } store_rsp_t;

  typedef struct packed {
    status_t   status;
    evt_time_t evt_time;
    hdr_t      hdr;
  } result_t;

endpackage

>>> hw/rtl/teq_store.sv
module teq_store (
  input  logic                clk,
  input  logic                rst_n,
  input  teq_pkg::store_req_t req,
  output teq_pkg::store_rsp_t rsp
);

  logic [teq_pkg::CAPACITY-1:0] valid_r;
  teq_pkg::evt_time_t           time_mem_r [teq_pkg::CAPACITY];
  teq_pkg::hdr_t                hdr_mem_r  [teq_pkg::CAPACITY];
  logic                         rd_valid_r;
  teq_pkg::evt_time_t           rd_time_r;
  teq_pkg::hdr_t                rd_hdr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (req.wr_en) begin
        valid_r[req.wr_addr] <= 1'b1;
      end
      if (req.clr_en) begin
        valid_r[req.clr_addr] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      time_mem_r[req.wr_addr] <= req.wr_time;
      hdr_mem_r[req.wr_addr]  <= req.wr_hdr;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_valid_r <= valid_r[req.rd_addr];
      rd_time_r  <= time_mem_r[req.rd_addr];
      rd_hdr_r   <= hdr_mem_r[req.rd_addr];
    end
  end

  assign rsp.rd_valid = rd_valid_r;
  assign rsp.rd_time  = rd_time_r;
  assign rsp.rd_hdr   = rd_hdr_r;

endmodule

>>> hw/rtl/teq_seq.sv
module teq_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_op,
  input  teq_pkg::evt_time_t   in_time,
  input  teq_pkg::hdr_t        in_hdr,
  output logic                 res_valid,
  input  logic                 res_ready,
  output teq_pkg::result_t     res,
  output teq_pkg::store_req_t  req,
  input  teq_pkg::store_rsp_t  rsp
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  state_t             state_r,     state_nxt;
  logic               issuing_r,   issuing_nxt;
  logic               pend_r,      pend_nxt;
  logic               pend_last_r, pend_last_nxt;
  logic               found_r,     found_nxt;
  teq_pkg::idx_t      idx_r,       idx_nxt;
  teq_pkg::idx_t      pend_idx_r,  pend_idx_nxt;
  teq_pkg::idx_t      best_idx_r,  best_idx_nxt;
  teq_pkg::evt_time_t best_time_r, best_time_nxt;
  teq_pkg::hdr_t      best_hdr_r,  best_hdr_nxt;
  logic               op_r,        op_nxt;
  teq_pkg::evt_time_t ins_time_r,  ins_time_nxt;
  teq_pkg::hdr_t      ins_hdr_r,   ins_hdr_nxt;
  teq_pkg::result_t   res_r,       res_nxt;
  logic               cand;

  // single comparator shared over the whole scan
  assign cand = rsp.rd_valid && (!found_r || (rsp.rd_time < best_time_r));

  always_comb begin
    state_nxt     = state_r;
    issuing_nxt   = issuing_r;
    pend_nxt      = pend_r;
    pend_last_nxt = pend_last_r;
    found_nxt     = found_r;
    idx_nxt       = idx_r;
    pend_idx_nxt  = pend_idx_r;
    best_idx_nxt  = best_idx_r;
    best_time_nxt = best_time_r;
    best_hdr_nxt  = best_hdr_r;
    op_nxt        = op_r;
    ins_time_nxt  = ins_time_r;
    ins_hdr_nxt   = ins_hdr_r;
    res_nxt       = res_r;
    req           = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt       = in_op;
          ins_time_nxt = in_time;
          ins_hdr_nxt  = in_hdr;
          idx_nxt      = '0;
          issuing_nxt  = 1'b1;
          pend_nxt     = 1'b0;
          found_nxt    = 1'b0;
          state_nxt    = S_SCAN;
        end
      end
      S_SCAN: begin
        if (issuing_r) begin
          req.rd_en     = 1'b1;
          req.rd_addr   = idx_r;
          pend_nxt      = 1'b1;
          pend_idx_nxt  = idx_r;
          pend_last_nxt = (idx_r == teq_pkg::LAST_IDX);
          if (idx_r == teq_pkg::LAST_IDX) begin
            issuing_nxt = 1'b0;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end else begin
          pend_nxt = 1'b0;
        end

        if (pend_r) begin
          if (op_r == teq_pkg::OP_INSERT) begin
            if (!rsp.rd_valid) begin
              req.wr_en   = 1'b1;
              req.wr_addr = pend_idx_r;
              req.wr_time = ins_time_r;
              req.wr_hdr  = ins_hdr_r;
              res_nxt     = '{status: teq_pkg::ST_INSERTED, evt_time: '0, hdr: '0};
              issuing_nxt = 1'b0;
              pend_nxt    = 1'b0;
              state_nxt   = S_DONE;
            end else if (pend_last_r) begin
              res_nxt   = '{status: teq_pkg::ST_FULL, evt_time: '0, hdr: '0};
              state_nxt = S_DONE;
            end
          end else begin
            if (cand) begin
              found_nxt     = 1'b1;
              best_idx_nxt  = pend_idx_r;
              best_time_nxt = rsp.rd_time;
              best_hdr_nxt  = rsp.rd_hdr;
            end
            if (pend_last_r) begin
              state_nxt = S_DONE;
              if (found_nxt) begin
                req.clr_en   = 1'b1;
                req.clr_addr = best_idx_nxt;
                res_nxt      = '{status: teq_pkg::ST_POPPED, evt_time: best_time_nxt,
                                 hdr: best_hdr_nxt};
              end else begin
                res_nxt = '{status: teq_pkg::ST_EMPTY, evt_time: '0, hdr: '0};
              end
            end
          end
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      issuing_r <= 1'b0;
      pend_r    <= 1'b0;
      found_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      issuing_r <= issuing_nxt;
      pend_r    <= pend_nxt;
      found_r   <= found_nxt;
    end
    pend_last_r <= pend_last_nxt;
    idx_r       <= idx_nxt;
    pend_idx_r  <= pend_idx_nxt;
    best_idx_r  <= best_idx_nxt;
    best_time_r <= best_time_nxt;
    best_hdr_r  <= best_hdr_nxt;
    op_r        <= op_nxt;
    ins_time_r  <= ins_time_nxt;
    ins_hdr_r   <= ins_hdr_nxt;
    res_r       <= res_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

endmodule

>>> hw/rtl/timed_event_queue.sv
// Timed event queue: a table of CAPACITY message events searched by linear scan.
// Input channel (in_*): one beat is an insert (operation 0) carrying a delivery
// time and message header, or a pop (operation 1) whose other fields are ignored.
// Output channel (out_*): one beat per input beat, in order. status is inserted,
// full, popped or empty; the event fields carry the popped entry, zero otherwise.
// Insert stores into the lowest free slot; pop returns the earliest time, lowest
// slot on ties, and frees it.
// Timing: the sequencer reads one slot per cycle from a table with registered
// read data and feeds one shared time comparator. An insert scan stops at the
// first free slot; a pop or a full insert scans all CAPACITY slots. in_ready is
// high only while the sequencer is idle.
// The output register decouples the sides: the next beat is accepted while a
// result waits; a stalled receiver holds the result and, once the next result
// is ready, holds the sequencer too.
// Reset clears all valid marks at once; the table is empty and usable right away.
module timed_event_queue (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_operation,
  input  logic [teq_pkg::TIME_W-1:0]        in_deliver_time,
  input  logic [teq_pkg::ID_W-1:0]          in_sender_id,
  input  logic [teq_pkg::ID_W-1:0]          in_receiver_id,
  input  logic [teq_pkg::ID_W-1:0]          in_origin_id,
  input  logic [teq_pkg::SEQ_W-1:0]         in_sequence_number,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        out_status,
  output logic [teq_pkg::TIME_W-1:0]        out_event_time,
  output logic [teq_pkg::ID_W-1:0]          out_event_sender,
  output logic [teq_pkg::ID_W-1:0]          out_event_receiver,
  output logic [teq_pkg::ID_W-1:0]          out_event_origin,
  output logic [teq_pkg::SEQ_W-1:0]         out_event_sequence
);

  teq_pkg::store_req_t req;
  teq_pkg::store_rsp_t rsp;
  teq_pkg::result_t    res;
  teq_pkg::hdr_t       in_hdr;
  logic                res_valid;
  logic                res_ready;
  logic                out_valid_r;
  teq_pkg::result_t    out_res_r;

  assign in_hdr = '{sequence_number: in_sequence_number, origin_id: in_origin_id,
                    receiver_id: in_receiver_id, sender_id: in_sender_id};

  teq_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_op     (in_operation),
    .in_time   (in_deliver_time),
    .in_hdr    (in_hdr),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .req       (req),
    .rsp       (rsp)
  );

  teq_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_res_r.status;
  assign out_event_time     = out_res_r.evt_time;
  assign out_event_sender   = out_res_r.hdr.sender_id;
  assign out_event_receiver = out_res_r.hdr.receiver_id;
  assign out_event_origin   = out_res_r.hdr.origin_id;
  assign out_event_sequence = out_res_r.hdr.sequence_number;

  // a beat starts a scan during which in_ready stays low
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready ##1 !in_ready)
    else $error("input accepted during scan");

  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != teq_pkg::ST_POPPED)) |->
      (out_event_time == '0) && (out_event_sender == '0) &&
      (out_event_receiver == '0) && (out_event_origin == '0) &&
      (out_event_sequence == '0))
    else $error("non-pop result carries event fields");

  a_result_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !in_ready)
    else $error("input ready while result pending");

  a_no_result_lost: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res_ready) |=> res_valid)
    else $error("pending result dropped");

endmodule

>>> test/timed_event_queue_test.sv
`timescale 1ns / 1ps

module timed_event_queue_test;
  import teq_pkg::*;

  localparam int STALL_LIMIT = 20 * CAPACITY;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic             in_operation = OP_INSERT;
  logic [TIME_W-1:0] in_deliver_time = '0;
  logic [ID_W-1:0]  in_sender_id = '0;
  logic [ID_W-1:0]  in_receiver_id = '0;
  logic [ID_W-1:0]  in_origin_id = '0;
  logic [SEQ_W-1:0] in_sequence_number = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [1:0]       out_status;
  logic [TIME_W-1:0] out_event_time;
  logic [ID_W-1:0]  out_event_sender;
  logic [ID_W-1:0]  out_event_receiver;
  logic [ID_W-1:0]  out_event_origin;
  logic [SEQ_W-1:0] out_event_sequence;

  // shadow of the event table
  bit        slot_taken [CAPACITY];
  evt_time_t slot_when [CAPACITY];
  hdr_t      slot_hdr [CAPACITY];

  result_t pending_answers [$];
  int      fail_count = 0;
  int      quiet_cycles = 0;
  bit      steady_flow = 1'b0;

  timed_event_queue u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_operation       (in_operation),
    .in_deliver_time    (in_deliver_time),
    .in_sender_id       (in_sender_id),
    .in_receiver_id     (in_receiver_id),
    .in_origin_id       (in_origin_id),
    .in_sequence_number (in_sequence_number),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_event_time     (out_event_time),
    .out_event_sender   (out_event_sender),
    .out_event_receiver (out_event_receiver),
    .out_event_origin   (out_event_origin),
    .out_event_sequence (out_event_sequence)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic result_t predict_answer(logic op, evt_time_t t, hdr_t h);
    result_t ans;
    int      pick;
    ans  = '0;
    pick = -1;
    if (op == OP_INSERT) begin
      ans.status = ST_FULL;
      for (int i = 0; i < CAPACITY; i++) begin
        if (!slot_taken[i] && pick < 0) pick = i;
      end
      if (pick >= 0) begin
        slot_taken[pick] = 1'b1;
        slot_when[pick]  = t;
        slot_hdr[pick]   = h;
        ans.status       = ST_INSERTED;
      end
    end else begin
      ans.status = ST_EMPTY;
      for (int i = 0; i < CAPACITY; i++) begin
        if (slot_taken[i] && (pick < 0 || slot_when[i] < slot_when[pick])) pick = i;
      end
      if (pick >= 0) begin
        ans.status       = ST_POPPED;
        ans.evt_time     = slot_when[pick];
        ans.hdr          = slot_hdr[pick];
        slot_taken[pick] = 1'b0;
      end
    end
    return ans;
  endfunction

  function automatic evt_time_t pick_time();
    evt_time_t t;
    case ($urandom_range(3))
      0: t = $urandom_range(15);
      1: t = $urandom;
      2: begin
        case ($urandom_range(3))
          0: t = 32'h0000_0000;
          1: t = 32'hFFFF_FFFF;
          2: t = 32'h8000_0000;
          default: t = 32'h7FFF_FFFF;
        endcase
      end
      default: t = 32'h8000_0000 + $urandom_range(15) - 8;
    endcase
    return t;
  endfunction

  task automatic send_item(input logic op, input evt_time_t t, input logic [ID_W-1:0] s,
                           input logic [ID_W-1:0] r, input logic [ID_W-1:0] o,
                           input logic [SEQ_W-1:0] sq);
    hdr_t h;
    int   lull;
    h.sender_id       = s;
    h.receiver_id     = r;
    h.origin_id       = o;
    h.sequence_number = sq;
    lull = 0;
    if (!steady_flow) begin
      if ($urandom_range(99) < 2) lull = $urandom_range(400, 1);
      else while ($urandom_range(99) < 22) lull++;
    end
    if (lull > 0) begin
      in_valid <= 1'b0;
      repeat (lull) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_operation       <= op;
    in_deliver_time    <= t;
    in_sender_id       <= s;
    in_receiver_id     <= r;
    in_origin_id       <= o;
    in_sequence_number <= sq;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_answers.push_back(predict_answer(op, t, h));
  endtask

  task automatic insert_event(input evt_time_t t, input logic [ID_W-1:0] s,
                              input logic [ID_W-1:0] r, input logic [ID_W-1:0] o,
                              input logic [SEQ_W-1:0] sq);
    send_item(OP_INSERT, t, s, r, o, sq);
  endtask

  task automatic insert_random();
    insert_event(pick_time(), ID_W'($urandom_range(15)), ID_W'($urandom_range(15)),
                 ID_W'($urandom_range(15)), SEQ_W'($urandom_range(16'hFFFF)));
  endtask

  // fields of a pop beat are don't-care, so fill them with noise
  task automatic pop_event();
    send_item(OP_POP, $urandom, ID_W'($urandom_range(15)), ID_W'($urandom_range(15)),
              ID_W'($urandom_range(15)), SEQ_W'($urandom_range(16'hFFFF)));
  endtask

  task automatic wait_all_answered();
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    pop_event();
    insert_event(32'h0000_0000, 4'h0, 4'h0, 4'h0, 16'h0000);
    insert_event(32'hFFFF_FFFF, 4'hF, 4'hF, 4'hF, 16'hFFFF);
    insert_event(32'h0000_0005, 4'h1, 4'h2, 4'h3, 16'h1234);
    insert_event(32'h0000_0005, 4'hA, 4'h5, 4'hC, 16'hABCD);
    insert_event(32'h8000_0000, 4'h7, 4'h8, 4'h9, 16'h8001);
    repeat (5) pop_event();
    pop_event();
    // freed low slot is reused and wins a time tie
    insert_event(32'd10, 4'h1, 4'h1, 4'h1, 16'd1);
    insert_event(32'd20, 4'h2, 4'h2, 4'h2, 16'd2);
    insert_event(32'd30, 4'h3, 4'h3, 4'h3, 16'd3);
    pop_event();
    insert_event(32'd20, 4'h4, 4'h4, 4'h4, 16'd4);
    repeat (3) pop_event();
    pop_event();
  endtask

  task automatic test_fill_and_drain();
    steady_flow = 1'b1;
    repeat (CAPACITY) insert_random();
    repeat (3) insert_random();
    repeat (CAPACITY + 1) pop_event();
    steady_flow = 1'b0;
    wait_all_answered();
  endtask

  task automatic test_random_mix();
    int insert_pct;
    for (int round = 0; round < 8; round++) begin
      if (round == 0) insert_pct = 90;
      else if (round == 7) insert_pct = 10;
      else insert_pct = $urandom_range(85, 15);
      repeat (145) begin
        if ($urandom_range(99) < insert_pct) insert_random();
        else pop_event();
      end
      if (round % 3 == 2) wait_all_answered();
    end
  endtask

  function automatic void compare_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    out_ready <= steady_flow || ($urandom_range(99) >= 22);
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_answers.size() == 0) begin
        $display("%0t ns: unexpected beat, expected none, actual status %0h time %0h",
                 $time, out_status, out_event_time);
        fail_count++;
      end else begin
        want = pending_answers.pop_front();
        compare_field("status", 32'(want.status), 32'(out_status));
        compare_field("event_time", want.evt_time, out_event_time);
        compare_field("event_sender", 32'(want.hdr.sender_id), 32'(out_event_sender));
        compare_field("event_receiver", 32'(want.hdr.receiver_id),
                      32'(out_event_receiver));
        compare_field("event_origin", 32'(want.hdr.origin_id), 32'(out_event_origin));
        compare_field("event_sequence", 32'(want.hdr.sequence_number),
                      32'(out_event_sequence));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t ns: no beat for %0d cycles", $time, STALL_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    wait_all_answered();
    test_fill_and_drain();
    test_random_mix();
    wait_all_answered();
    repeat (2 * CAPACITY) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
